// ===== rtl/blkaddr_pkg.sv =====
// ----------------------------------------------------------------------------
// blkaddr_pkg
// Shared types and constants of the blocked array address generator.
// ----------------------------------------------------------------------------
package blkaddr_pkg;

	localparam int DIM_W   = 12;
	localparam int SIZE_W  = 13;
	localparam int TILE_W  = 9;
	localparam int CELL_W  = 8;
	localparam int EB_W    = 5;
	localparam int BLK_W   = 24;
	localparam int CIDX_W  = 16;
	localparam int OFF_W   = 32;
	localparam int CFG_IDX_W = 3;

	localparam int MAX_DIM  = 4096;
	localparam int MAX_TILE = 256;
	localparam int MAX_EB   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIDE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 3'd3;

	localparam logic OP_LOOKUP   = 1'b0;
	localparam logic OP_TRAVERSE = 1'b1;

	// divider: dividend up to width + side - 1, divisor is the tile side
	localparam int DVD_W = SIZE_W;
	localparam int DVS_W = TILE_W;
	localparam int DCNT_W = $clog2(DVD_W + 1);

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== rtl/blocked_array_address_generator_core.sv =====
// ----------------------------------------------------------------------------
// blocked_array_address_generator_core
// Maps coordinates of a tiled 2-D array to block, cell and byte offset, and
// walks the array block by block.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+---------------------------
//  s_axis   | tvalid tready tdata tuser        | lookup or walk request
//  m_axis   | tvalid tready tdata tuser tlast  | address result
//  cfg      | valid ready index data           | register write
//
// A lookup in range runs through the shared bit-serial divider (column, then
// row) and the shared multiplier (5 steps). A walk step uses only the
// multiplier; an out-of-range lookup goes straight to the result.
// A write to a mapped register reruns the blocks-per-row division.
// A held result does not block the next item until its own result is done.
// ----------------------------------------------------------------------------
module blocked_array_address_generator_core
	import blkaddr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // column, row
	input  logic                 s_axis_tuser,   // operation
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [95:0]          m_axis_tdata,   // out_column, out_row, block_index,
	                                             // cell_index, byte_offset
	output logic                 m_axis_tuser,   // out_of_range
	output logic                 m_axis_tlast,   // last_cell
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_PRE_GO, S_PRE, S_DIV_C, S_DIV_R, S_MUL_BLK, S_MUL_CELL,
		S_MUL_SQ, S_MUL_OFF1, S_MUL_OFF2, S_DONE
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0] width_q, height_q, per_row_q;
	logic [TILE_W-1:0] bs_q;
	logic [EB_W-1:0]   eb_q;

	logic [DIM_W-1:0]  walk_block_row_q, walk_block_col_q, base_row_q, base_col_q;
	logic [CELL_W-1:0] walk_cell_row_q, walk_cell_col_q;

	logic [DIM_W-1:0]  res_col_q, res_row_q, q_col_q, q_row_q;
	logic [CELL_W-1:0] r_col_q, r_row_q;
	logic [BLK_W-1:0]  blk_q;
	logic [CIDX_W-1:0] cell_q;
	logic [16:0]       bs2_q;
	logic [24:0]       sum_q;
	logic              ovf_q;
	logic [OFF_W-1:0]  off_q;
	logic              oor_q, last_q;

	logic              div_start_q;
	logic [DVD_W-1:0]  div_dvd_q;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              m_valid_q, m_oor_q, m_last_q;
	logic [95:0]       m_data_q;

	logic [DIM_W-1:0]  in_col, in_row;
	logic              s_acc, cfg_acc, out_free;
	logic [SIZE_W-1:0] t_col, t_row, nb_col, nb_row;
	logic              adv_col, adv_row, more_bcol, more_brow;
	logic [24:0]       mul_a;
	logic [16:0]       mul_b;
	logic [41:0]       mul_p;
	logic [41:0]       off_sum;

	assign in_col = s_axis_tdata[11:0];
	assign in_row = s_axis_tdata[23:12];

	assign cfg_ready     = (state_q == S_IDLE);
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// walk advance decisions
	assign t_col     = SIZE_W'(base_col_q) + SIZE_W'(walk_cell_col_q);
	assign t_row     = SIZE_W'(base_row_q) + SIZE_W'(walk_cell_row_q);
	assign adv_col   = (TILE_W'(walk_cell_col_q) + 1'b1 < bs_q) && (t_col + 1'b1 < width_q);
	assign adv_row   = (TILE_W'(walk_cell_row_q) + 1'b1 < bs_q) && (t_row + 1'b1 < height_q);
	assign nb_col    = SIZE_W'(base_col_q) + SIZE_W'(bs_q);
	assign nb_row    = SIZE_W'(base_row_q) + SIZE_W'(bs_q);
	assign more_bcol = nb_col < width_q;
	assign more_brow = nb_row < height_q;

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_BLK: begin
				mul_a = 25'(per_row_q);
				mul_b = 17'(q_row_q);
			end
			S_MUL_CELL: begin
				mul_a = 25'(bs_q);
				mul_b = 17'(r_row_q);
			end
			S_MUL_SQ: begin
				mul_a = 25'(bs_q);
				mul_b = 17'(bs_q);
			end
			S_MUL_OFF1: begin
				mul_a = 25'(blk_q);
				mul_b = bs2_q;
			end
			S_MUL_OFF2: begin
				mul_a = sum_q;
				mul_b = 17'(eb_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = 42'(mul_a) * 42'(mul_b);
	assign off_sum = mul_p + 42'(cell_q);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dvd_q;
	assign div_req.divisor  = bs_q;

	blkaddr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			width_q          <= '0;
			height_q         <= '0;
			bs_q             <= TILE_W'(1);
			eb_q             <= EB_W'(1);
			per_row_q        <= '0;
			walk_block_row_q <= '0;
			walk_block_col_q <= '0;
			walk_cell_row_q  <= '0;
			walk_cell_col_q  <= '0;
			base_row_q       <= '0;
			base_col_q       <= '0;
			res_col_q        <= '0;
			res_row_q        <= '0;
			q_col_q          <= '0;
			q_row_q          <= '0;
			r_col_q          <= '0;
			r_row_q          <= '0;
			blk_q            <= '0;
			cell_q           <= '0;
			bs2_q            <= '0;
			sum_q            <= '0;
			ovf_q            <= 1'b0;
			off_q            <= '0;
			oor_q            <= 1'b0;
			last_q           <= 1'b0;
			div_start_q      <= 1'b0;
			div_dvd_q        <= '0;
			m_valid_q        <= 1'b0;
			m_oor_q          <= 1'b0;
			m_last_q         <= 1'b0;
			m_data_q         <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						if (cfg_index == CFG_ARRAY_WIDTH || cfg_index == CFG_ARRAY_HEIGHT ||
						    cfg_index == CFG_TILE_SIDE || cfg_index == CFG_ELEMENT_BYTES) begin
							walk_block_row_q <= '0;
							walk_block_col_q <= '0;
							walk_cell_row_q  <= '0;
							walk_cell_col_q  <= '0;
							base_row_q       <= '0;
							base_col_q       <= '0;
							state_q          <= S_PRE_GO;
						end
						case (cfg_index)
							CFG_ARRAY_WIDTH:
								width_q <= (cfg_data > SIZE_W'(MAX_DIM)) ?
									SIZE_W'(MAX_DIM) : cfg_data;
							CFG_ARRAY_HEIGHT:
								height_q <= (cfg_data > SIZE_W'(MAX_DIM)) ?
									SIZE_W'(MAX_DIM) : cfg_data;
							CFG_TILE_SIDE:
								if (cfg_data[TILE_W-1:0] == '0)
									bs_q <= TILE_W'(1);
								else if (cfg_data[TILE_W-1:0] > TILE_W'(MAX_TILE))
									bs_q <= TILE_W'(MAX_TILE);
								else
									bs_q <= cfg_data[TILE_W-1:0];
							CFG_ELEMENT_BYTES:
								if (cfg_data[EB_W-1:0] == '0)
									eb_q <= EB_W'(1);
								else if (cfg_data[EB_W-1:0] > EB_W'(MAX_EB))
									eb_q <= EB_W'(MAX_EB);
								else
									eb_q <= cfg_data[EB_W-1:0];
							default: ;
						endcase
					end else if (s_acc) begin
						if (s_axis_tuser == OP_LOOKUP) begin
							res_col_q <= in_col;
							res_row_q <= in_row;
							last_q    <= 1'b0;
							if ({1'b0, in_col} >= width_q || {1'b0, in_row} >= height_q) begin
								oor_q   <= 1'b1;
								blk_q   <= '0;
								cell_q  <= '0;
								off_q   <= '0;
								state_q <= S_DONE;
							end else begin
								oor_q       <= 1'b0;
								div_start_q <= 1'b1;
								div_dvd_q   <= DVD_W'(in_col);
								state_q     <= S_DIV_C;
							end
						end else if (width_q == '0 || height_q == '0) begin
							res_col_q <= '0;
							res_row_q <= '0;
							oor_q     <= 1'b1;
							last_q    <= 1'b0;
							blk_q     <= '0;
							cell_q    <= '0;
							off_q     <= '0;
							state_q   <= S_DONE;
						end else begin
							res_col_q <= t_col[DIM_W-1:0];
							res_row_q <= t_row[DIM_W-1:0];
							q_col_q   <= walk_block_col_q;
							q_row_q   <= walk_block_row_q;
							r_col_q   <= walk_cell_col_q;
							r_row_q   <= walk_cell_row_q;
							oor_q     <= 1'b0;
							last_q    <= 1'b0;
							state_q   <= S_MUL_BLK;
							if (adv_col) begin
								walk_cell_col_q <= walk_cell_col_q + 1'b1;
							end else begin
								walk_cell_col_q <= '0;
								if (adv_row) begin
									walk_cell_row_q <= walk_cell_row_q + 1'b1;
								end else begin
									walk_cell_row_q <= '0;
									if (more_bcol) begin
										walk_block_col_q <= walk_block_col_q + 1'b1;
										base_col_q       <= nb_col[DIM_W-1:0];
									end else begin
										walk_block_col_q <= '0;
										base_col_q       <= '0;
										if (more_brow) begin
											walk_block_row_q <= walk_block_row_q + 1'b1;
											base_row_q       <= nb_row[DIM_W-1:0];
										end else begin
											walk_block_row_q <= '0;
											base_row_q       <= '0;
											last_q           <= 1'b1;
										end
									end
								end
							end
						end
					end
				end
				S_PRE_GO: begin
					div_start_q <= 1'b1;
					div_dvd_q   <= width_q + SIZE_W'(bs_q) - 1'b1;
					state_q     <= S_PRE;
				end
				S_PRE: begin
					if (div_rsp.done) begin
						per_row_q <= div_rsp.quotient;
						state_q   <= S_IDLE;
					end
				end
				S_DIV_C: begin
					if (div_rsp.done) begin
						q_col_q     <= div_rsp.quotient[DIM_W-1:0];
						r_col_q     <= div_rsp.remainder[CELL_W-1:0];
						div_start_q <= 1'b1;
						div_dvd_q   <= DVD_W'(res_row_q);
						state_q     <= S_DIV_R;
					end
				end
				S_DIV_R: begin
					if (div_rsp.done) begin
						q_row_q <= div_rsp.quotient[DIM_W-1:0];
						r_row_q <= div_rsp.remainder[CELL_W-1:0];
						state_q <= S_MUL_BLK;
					end
				end
				S_MUL_BLK: begin
					blk_q   <= BLK_W'(mul_p + 42'(q_col_q));
					state_q <= S_MUL_CELL;
				end
				S_MUL_CELL: begin
					cell_q  <= CIDX_W'(mul_p + 42'(r_col_q));
					state_q <= S_MUL_SQ;
				end
				S_MUL_SQ: begin
					bs2_q   <= mul_p[16:0];
					state_q <= S_MUL_OFF1;
				end
				S_MUL_OFF1: begin
					sum_q   <= off_sum[24:0];
					ovf_q   <= |off_sum[41:25];
					state_q <= S_MUL_OFF2;
				end
				S_MUL_OFF2: begin
					off_q   <= (ovf_q || |mul_p[41:32]) ? '1 : mul_p[31:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_oor_q   <= oor_q;
						m_last_q  <= last_q;
						m_data_q  <= {off_q, cell_q, blk_q, res_row_q, res_col_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_oor_q;
	assign m_axis_tlast  = m_last_q;

endmodule

// ===== rtl/blkaddr_div.sv =====
// ----------------------------------------------------------------------------
// blkaddr_div
// Restoring divider, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module blkaddr_div
	import blkaddr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    shifted;
	logic              ge;
	logic [DVS_W:0]    diff;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, req.divisor};
	assign diff    = shifted - {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				quo_q  <= req.dividend;
				rem_q  <= '0;
				cnt_q  <= DCNT_W'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/blkaddr_chk.sv =====
// ----------------------------------------------------------------------------
// blkaddr_chk
// Port-level checks of the blocked array address generator, bound to the top.
// ----------------------------------------------------------------------------
module blkaddr_chk
	import blkaddr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [23:0]          s_axis_tdata,
	input logic                 s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [95:0]          m_axis_tdata,
	input logic                 m_axis_tuser,
	input logic                 m_axis_tlast,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [SIZE_W-1:0]    cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_oor_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
		else $error("out-of-range item flagged as last cell");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[95:24] == '0)
		else $error("out-of-range item carries an address");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item taken while previous item in progress");

	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && s_axis_tvalid && s_axis_tready))
		else $error("register write and item taken together");

endmodule

bind blocked_array_address_generator_core blkaddr_chk u_blkaddr_chk (.*);

// ===== sim/blocked_array_address_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// blocked_array_address_generator_core_tb
// Self-checking bench for the blocked array address generator. Lookup and walk
// items go into the stream input, and each returned address is checked field
// by field against an in-bench copy of the tiling arithmetic and walk state.
// Array geometry is rewritten between phases while the block is idle. The
// stimulus covers empty arrays, clamped register values and wrapping walks.
// ----------------------------------------------------------------------------
module blocked_array_address_generator_core_tb;
	import blkaddr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int unsigned COORD_MAX = (1 << DIM_W) - 1;

	typedef struct packed {
		logic             op;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
	} req_t;

	typedef struct packed {
		logic [DIM_W-1:0]  col;
		logic [DIM_W-1:0]  row;
		logic [BLK_W-1:0]  blk;
		logic [CIDX_W-1:0] cidx;
		logic [OFF_W-1:0]  off;
		logic              oor;
		logic              last;
	} addr_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;   // column, row
	logic                 s_axis_tuser = 1'b0; // operation
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [95:0]          m_axis_tdata;        // out_column, out_row, block_index,
	                                           // cell_index, byte_offset
	logic                 m_axis_tuser;        // out_of_range
	logic                 m_axis_tlast;        // last_cell
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_data = '0;

	req_t        pending_req[$];
	addr_res_t   expected_addr[$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	// geometry and walk position as the block should hold them
	int unsigned      cur_width = 0;
	int unsigned      cur_height = 0;
	int unsigned      cur_side = 1;
	int unsigned      cur_eb = 1;
	logic [DIM_W-1:0]  walk_brow = '0;
	logic [DIM_W-1:0]  walk_bcol = '0;
	logic [CELL_W-1:0] walk_crow = '0;
	logic [CELL_W-1:0] walk_ccol = '0;

	blocked_array_address_generator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial forever #6 clk = ~clk;

	initial begin
		#6000000;
		$display("blocked_array_address_generator_core_tb failed");
		$finish;
	end

	function automatic void restart_walk();
		walk_brow = '0;
		walk_bcol = '0;
		walk_crow = '0;
		walk_ccol = '0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
		int unsigned v;
		case (idx)
			CFG_ARRAY_WIDTH: begin
				v = 32'(val);
				cur_width = (v > MAX_DIM) ? MAX_DIM : v;
			end
			CFG_ARRAY_HEIGHT: begin
				v = 32'(val);
				cur_height = (v > MAX_DIM) ? MAX_DIM : v;
			end
			CFG_TILE_SIDE: begin
				v = 32'(val[TILE_W-1:0]);
				if (v == 0)
					v = 1;
				cur_side = (v > MAX_TILE) ? MAX_TILE : v;
			end
			CFG_ELEMENT_BYTES: begin
				v = 32'(val[EB_W-1:0]);
				if (v == 0)
					v = 1;
				cur_eb = (v > MAX_EB) ? MAX_EB : v;
			end
			default: return;
		endcase
		restart_walk();
	endfunction

	function automatic addr_res_t map_cell(int unsigned col, int unsigned row, logic last);
		longint unsigned bs, per_row, blk, cell_idx, off;
		addr_res_t r;
		bs = cur_side;
		per_row = (cur_width + bs - 1) / bs;
		blk = per_row * (row / bs) + col / bs;
		cell_idx = bs * (row % bs) + col % bs;
		off = (blk * bs * bs + cell_idx) * cur_eb;
		r.col = col[DIM_W-1:0];
		r.row = row[DIM_W-1:0];
		r.blk = blk[BLK_W-1:0];
		r.cidx = cell_idx[CIDX_W-1:0];
		r.off = (off > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : off[OFF_W-1:0];
		r.oor = 1'b0;
		r.last = last;
		return r;
	endfunction

	function automatic addr_res_t predict_addr(req_t q);
		int unsigned bs, tiles_x, tiles_y, col, row;
		logic last;
		addr_res_t r;
		r = '0;
		bs = cur_side;
		if (q.op == OP_LOOKUP) begin
			if (q.col >= cur_width || q.row >= cur_height) begin
				r.col = q.col;
				r.row = q.row;
				r.oor = 1'b1;
				return r;
			end
			return map_cell(32'(q.col), 32'(q.row), 1'b0);
		end
		if (cur_width == 0 || cur_height == 0) begin
			r.oor = 1'b1;
			return r;
		end
		tiles_x = (cur_width + bs - 1) / bs;
		tiles_y = (cur_height + bs - 1) / bs;
		col = walk_bcol * bs + walk_ccol;
		row = walk_brow * bs + walk_crow;
		last = 1'b0;
		if (walk_ccol >= bs || walk_crow >= bs || col >= cur_width || row >= cur_height) begin
			restart_walk();
			col = 0;
			row = 0;
		end
		if (walk_ccol + 1 < bs && col + 1 < cur_width) begin
			walk_ccol = walk_ccol + 1'b1;
		end else begin
			walk_ccol = '0;
			if (walk_crow + 1 < bs && row + 1 < cur_height) begin
				walk_crow = walk_crow + 1'b1;
			end else begin
				walk_crow = '0;
				if (walk_bcol + 1 < tiles_x) begin
					walk_bcol = walk_bcol + 1'b1;
				end else begin
					walk_bcol = '0;
					if (walk_brow + 1 < tiles_y) begin
						walk_brow = walk_brow + 1'b1;
					end else begin
						walk_brow = '0;
						last = 1'b1;
					end
				end
			end
		end
		return map_cell(col, row, last);
	endfunction

	function automatic void check_field(string name, logic [OFF_W-1:0] want,
			logic [OFF_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tuser <= OP_LOOKUP;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid)
				expected_addr.push_back(predict_addr(req_t'({s_axis_tuser, s_axis_tdata})));
			if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_req.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nxt.op;
				s_axis_tdata <= {nxt.row, nxt.col};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		addr_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_addr.size() == 0) begin
				$error("address result with no request pending");
				mismatches++;
			end else begin
				want = expected_addr.pop_front();
				check_field("out_column", OFF_W'(want.col), OFF_W'(m_axis_tdata[11:0]));
				check_field("out_row", OFF_W'(want.row), OFF_W'(m_axis_tdata[23:12]));
				check_field("block_index", OFF_W'(want.blk), OFF_W'(m_axis_tdata[47:24]));
				check_field("cell_index", OFF_W'(want.cidx), OFF_W'(m_axis_tdata[63:48]));
				check_field("byte_offset", want.off, m_axis_tdata[95:64]);
				check_field("out_of_range", OFF_W'(want.oor), OFF_W'(m_axis_tuser));
				check_field("last_cell", OFF_W'(want.last), OFF_W'(m_axis_tlast));
			end
		end
	end

	task automatic queue_req(logic op, logic [DIM_W-1:0] col, logic [DIM_W-1:0] row);
		req_t q;
		q.op = op;
		q.col = col;
		q.row = row;
		pending_req.push_back(q);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_req.size() != 0 || s_axis_tvalid || expected_addr.size() != 0);
	endtask

	task automatic random_geometry();
		int unsigned shape;
		logic [SIZE_W-1:0] w, h, side, eb;
		shape = $urandom_range(0, 9);
		w = SIZE_W'($urandom_range(1, 12));
		h = SIZE_W'($urandom_range(1, 12));
		side = SIZE_W'($urandom_range(1, 5));
		eb = SIZE_W'($urandom);
		if (shape == 7) begin
			w = $urandom_range(0, 1) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, MAX_DIM));
			h = $urandom_range(0, 1) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, MAX_DIM));
			side = SIZE_W'($urandom);
		end else if (shape == 8) begin
			if ($urandom_range(0, 1))
				w = '0;
			else
				h = '0;
		end else if (shape == 9) begin
			w = SIZE_W'(MAX_DIM);
			h = SIZE_W'($urandom_range(1, 8));
			side = SIZE_W'(MAX_TILE);
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, SIZE_W'($urandom));
		write_reg(CFG_TILE_SIDE, side);
		write_reg(CFG_ARRAY_WIDTH, w);
		write_reg(CFG_ARRAY_HEIGHT, h);
		write_reg(CFG_ELEMENT_BYTES, eb);
	endtask

	task automatic random_req();
		int unsigned pick;
		logic [DIM_W-1:0] c, r;
		pick = $urandom_range(0, 9);
		c = DIM_W'($urandom);
		r = DIM_W'($urandom);
		if (pick < 6) begin
			queue_req(OP_TRAVERSE, c, r);
		end else begin
			if (pick < 9) begin
				c = DIM_W'($urandom_range(0,
					(cur_width < COORD_MAX) ? cur_width + 1 : COORD_MAX));
				r = DIM_W'($urandom_range(0,
					(cur_height < COORD_MAX) ? cur_height + 1 : COORD_MAX));
			end
			queue_req(OP_LOOKUP, c, r);
		end
	endtask

	initial begin
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 35;
		recv_idle_pct = 60;

		// empty array right after reset
		queue_req(OP_LOOKUP, 12'd0, 12'd0);
		queue_req(OP_LOOKUP, 12'hFFF, 12'hFFF);
		queue_req(OP_TRAVERSE, 12'hFFF, 12'hFFF);
		drain();

		// 5x3 array of 2x2 tiles: full walk plus wrap, edge and outside lookups
		write_reg(CFG_ARRAY_WIDTH, 13'd5);
		write_reg(CFG_ARRAY_HEIGHT, 13'd3);
		write_reg(CFG_TILE_SIDE, 13'd2);
		write_reg(CFG_ELEMENT_BYTES, 13'd16);
		repeat (16) queue_req(OP_TRAVERSE, DIM_W'($urandom), DIM_W'($urandom));
		queue_req(OP_LOOKUP, 12'd4, 12'd2);
		queue_req(OP_LOOKUP, 12'd5, 12'd1);
		queue_req(OP_LOOKUP, 12'd2, 12'd3);
		drain();

		// clamped extremes
		write_reg(CFG_ARRAY_WIDTH, 13'h1FFF);
		write_reg(CFG_ARRAY_HEIGHT, SIZE_W'(MAX_DIM));
		write_reg(CFG_TILE_SIDE, 13'd0);
		write_reg(CFG_ELEMENT_BYTES, 13'd0);
		queue_req(OP_LOOKUP, 12'hFFF, 12'hFFF);
		queue_req(OP_TRAVERSE, 12'd0, 12'd0);
		drain();
		write_reg(CFG_TILE_SIDE, 13'h1FF);
		write_reg(CFG_ELEMENT_BYTES, 13'h1F);
		queue_req(OP_LOOKUP, 12'hFFF, 12'hFFF);
		queue_req(OP_TRAVERSE, 12'd0, 12'd0);
		drain();
		// a write to an unmapped index must leave the walk where it is
		write_reg(CFG_UNUSED, 13'h1FFF);
		queue_req(OP_TRAVERSE, 12'd0, 12'd0);
		drain();

		for (phase = 0; phase < 12; phase++) begin
			if (phase == 4) begin
				send_idle_pct = 60;
				recv_idle_pct = 35;
			end else if (phase == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_geometry();
			repeat ($urandom_range(25, 50)) random_req();
			drain();
		end

		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("blocked_array_address_generator_core_tb passed");
		else
			$display("blocked_array_address_generator_core_tb failed");
		$finish;
	end

endmodule
